FILE: src/c65_pkg.sv
// ----------------------------------------------------------------------------
// c65_pkg: shared types and constants for the 6502 subset executor
// Holds the channel payload structs, the opcode values, the instruction
// classes the front end hands to the back end, and the flag bit masks.
// ----------------------------------------------------------------------------
package c65_pkg;

	// Opcode values of the supported instructions
	localparam logic [7:0] OPC_CLD = 8'hD8;
	localparam logic [7:0] OPC_SEI = 8'h78;
	localparam logic [7:0] OPC_LDX = 8'hA2;
	localparam logic [7:0] OPC_STX = 8'h8E;
	localparam logic [7:0] OPC_LDA = 8'hAD;
	localparam logic [7:0] OPC_BPL = 8'h10;
	localparam logic [7:0] OPC_DEX = 8'hCA;
	localparam logic [7:0] OPC_TXS = 8'h9A;

	// Flag masks
	localparam logic [7:0] FLAG_N     = 8'b1000_0000;
	localparam logic [7:0] FLAG_I     = 8'b0000_0100;
	localparam logic [7:0] FLAG_Z     = 8'b0000_0010;
	localparam logic [7:0] CLR_D_MASK = 8'b1111_0111;

	// Result status codes
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_BAD = 1'b1;

	// Instruction queue between front and back end
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = 1;
	localparam int unsigned QCNT_W      = 2;

	typedef enum logic [3:0] {
		CLS_CLD,
		CLS_SEI,
		CLS_LDX,
		CLS_STX,
		CLS_LDA,
		CLS_BPL,
		CLS_DEX,
		CLS_TXS,
		CLS_BAD
	} op_class_t;

	typedef struct packed {
		logic [7:0] opcode;
		logic [7:0] operand_low;
		logic [7:0] operand_high;
	} req_t;

	typedef struct packed {
		logic        status;
		logic [15:0] next_pc;
		logic [7:0]  acc_out;
		logic [7:0]  xreg_out;
		logic [7:0]  stack_out;
		logic [7:0]  flags_out;
	} rsp_t;

	// Classified instruction as it sits in the queue
	typedef struct packed {
		op_class_t  cls;
		logic [7:0] lo;
		logic [7:0] hi;
	} entry_t;

	// Queue head as seen by the back end
	typedef struct packed {
		logic   valid;
		entry_t entry;
	} head_t;

	// Update Z and N from a value, keep the other flags
	function automatic logic [7:0] set_zn(input logic [7:0] flags, input logic [7:0] v);
		logic [7:0] f;
		f = flags & ~(FLAG_Z | FLAG_N);
		if (v == 8'd0) begin
			f = f | FLAG_Z;
		end
		if (v[7]) begin
			f = f | FLAG_N;
		end
		return f;
	endfunction

endpackage

FILE: src/cpu6502_subset_executor.sv
// A result passes through the queue and then the result register; an LDA
// goes through the queue, the registered RAM read and the result register.
// One item per cycle unless stalled; a pending LDA read holds the queue.
// A two-entry queue decouples intake from execution under output stall.
// Reset: A, X, SP, flags and PC clear to zero and the queue empties at once;
// the data RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// cpu6502_subset_executor: 6502 instruction subset executor
// Front end classifies instructions into a queue; back end executes them
// against A, X, SP, flags, PC and a data RAM and returns the new state.
// ----------------------------------------------------------------------------
module cpu6502_subset_executor #(
	parameter int unsigned MEM_ADDR_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  c65_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output c65_pkg::rsp_t rsp
);

	c65_pkg::head_t head;
	logic           pop;

	c65_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.head     (head),
		.pop      (pop)
	);

	c65_back #(
		.MEM_ADDR_BITS(MEM_ADDR_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule

FILE: src/c65_ram.sv
// ----------------------------------------------------------------------------
// c65_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered and holds
// until the next read.
// ----------------------------------------------------------------------------
module c65_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: src/c65_front.sv
// ----------------------------------------------------------------------------
// c65_front: instruction intake and classification
// Accepts request items, decodes the opcode into an instruction class and
// holds the classified items in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module c65_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  c65_pkg::req_t req,
	output c65_pkg::head_t head,
	input  logic          pop
);

	c65_pkg::entry_t          entry_q [c65_pkg::QUEUE_DEPTH];
	c65_pkg::entry_t          new_entry;
	logic [c65_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [c65_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [c65_pkg::QCNT_W-1:0] cnt_q;
	logic                     push;

	// Classify the opcode
	always_comb begin
		new_entry.lo = req.operand_low;
		new_entry.hi = req.operand_high;
		case (req.opcode)
			c65_pkg::OPC_CLD: new_entry.cls = c65_pkg::CLS_CLD;
			c65_pkg::OPC_SEI: new_entry.cls = c65_pkg::CLS_SEI;
			c65_pkg::OPC_LDX: new_entry.cls = c65_pkg::CLS_LDX;
			c65_pkg::OPC_STX: new_entry.cls = c65_pkg::CLS_STX;
			c65_pkg::OPC_LDA: new_entry.cls = c65_pkg::CLS_LDA;
			c65_pkg::OPC_BPL: new_entry.cls = c65_pkg::CLS_BPL;
			c65_pkg::OPC_DEX: new_entry.cls = c65_pkg::CLS_DEX;
			c65_pkg::OPC_TXS: new_entry.cls = c65_pkg::CLS_TXS;
			default:          new_entry.cls = c65_pkg::CLS_BAD;
		endcase
	end

	assign req_stall = (cnt_q == c65_pkg::QCNT_W'(c65_pkg::QUEUE_DEPTH));
	assign push      = req_valid && !req_stall;

	// Store classified items
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= new_entry;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign head.valid = (cnt_q != '0);
	assign head.entry = entry_q[rd_ptr_q];

endmodule

FILE: src/c65_back.sv
// ----------------------------------------------------------------------------
// c65_back: instruction execution
// Takes classified items from the queue, updates the architectural
// registers and the data RAM, and loads the result register. LDA issues a
// RAM read and completes from the registered read data once the result register can take it.
// ----------------------------------------------------------------------------
module c65_back #(
	parameter int unsigned MEM_ADDR_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  c65_pkg::head_t head,
	output logic           pop,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output c65_pkg::rsp_t  rsp
);

	localparam int unsigned MemDepth = 1 << MEM_ADDR_BITS;

	logic [7:0]  acc_q, x_q, sp_q, flags_q;
	logic [15:0] pc_q;
	logic        pend_q;
	logic        rsp_valid_q;
	c65_pkg::rsp_t rsp_q;

	logic [7:0]  acc_d, x_d, sp_d, flags_d;
	logic [15:0] pc_d;
	logic        status_d;
	logic        can_load, exec_now, lda_issue, lda_done, rsp_load;
	logic [15:0] abs_addr;
	logic [MEM_ADDR_BITS-1:0] mem_addr;
	logic [7:0]  rd_data;
	logic        is_lda;

	assign is_lda    = (head.entry.cls == c65_pkg::CLS_LDA);
	assign can_load  = !rsp_valid_q || !rsp_stall;
	assign exec_now  = head.valid && !pend_q && can_load && !is_lda;
	assign lda_issue = head.valid && !pend_q && is_lda;
	assign lda_done  = pend_q && can_load;
	assign pop       = exec_now || lda_issue;
	assign rsp_load  = exec_now || lda_done;
	assign abs_addr  = {head.entry.hi, head.entry.lo};
	assign mem_addr  = abs_addr[MEM_ADDR_BITS-1:0];

	c65_ram #(
		.WIDTH(8),
		.DEPTH(MemDepth)
	) u_ram (
		.clk    (clk),
		.wr_en  (exec_now && head.entry.cls == c65_pkg::CLS_STX),
		.wr_addr(mem_addr),
		.wr_data(x_q),
		.rd_en  (lda_issue),
		.rd_addr(mem_addr),
		.rd_data(rd_data)
	);

	// Compute the next architectural state
	always_comb begin
		acc_d    = acc_q;
		x_d      = x_q;
		sp_d     = sp_q;
		flags_d  = flags_q;
		pc_d     = pc_q;
		status_d = c65_pkg::STATUS_OK;
		if (pend_q) begin
			acc_d   = rd_data;
			flags_d = c65_pkg::set_zn(flags_q, rd_data);
			pc_d    = pc_q + 16'd3;
		end else begin
			case (head.entry.cls)
				c65_pkg::CLS_CLD: begin
					flags_d = flags_q & c65_pkg::CLR_D_MASK;
					pc_d    = pc_q + 16'd1;
				end
				c65_pkg::CLS_SEI: begin
					flags_d = flags_q | c65_pkg::FLAG_I;
					pc_d    = pc_q + 16'd1;
				end
				c65_pkg::CLS_LDX: begin
					x_d     = head.entry.lo;
					flags_d = c65_pkg::set_zn(flags_q, head.entry.lo);
					pc_d    = pc_q + 16'd2;
				end
				c65_pkg::CLS_STX: begin
					pc_d = pc_q + 16'd3;
				end
				c65_pkg::CLS_BPL: begin
					if ((flags_q & c65_pkg::FLAG_N) == 8'd0) begin
						pc_d = pc_q + 16'd2 + {{8{head.entry.lo[7]}}, head.entry.lo};
					end else begin
						pc_d = pc_q + 16'd2;
					end
				end
				c65_pkg::CLS_DEX: begin
					x_d     = x_q - 8'd1;
					flags_d = c65_pkg::set_zn(flags_q, x_q - 8'd1);
					pc_d    = pc_q + 16'd1;
				end
				c65_pkg::CLS_TXS: begin
					sp_d = x_q;
					pc_d = pc_q + 16'd1;
				end
				default: begin
					status_d = c65_pkg::STATUS_BAD;
				end
			endcase
		end
	end

	// Commit state and track the pending load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			x_q         <= '0;
			sp_q        <= '0;
			flags_q     <= '0;
			pc_q        <= '0;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				acc_q   <= acc_d;
				x_q     <= x_d;
				sp_q    <= sp_d;
				flags_q <= flags_d;
				pc_q    <= pc_d;
			end
			if (lda_issue) begin
				pend_q <= 1'b1;
			end else if (lda_done) begin
				pend_q <= 1'b0;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.status    <= status_d;
			rsp_q.next_pc   <= pc_d;
			rsp_q.acc_out   <= acc_d;
			rsp_q.xreg_out  <= x_d;
			rsp_q.stack_out <= sp_d;
			rsp_q.flags_out <= flags_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_pend_blocks_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !pop)
		else $error("queue popped while a load is pending");

	a_lda_sets_pend: assert property (@(posedge clk) disable iff (!arst_n)
		lda_issue |=> pend_q && !rsp_valid_q || pend_q)
		else $error("load issued without pending flag");

	a_done_clears_pend: assert property (@(posedge clk) disable iff (!arst_n)
		lda_done |=> !pend_q && rsp_valid_q)
		else $error("completed load left pending or produced no result");

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the 6502 subset executor
// Sends instruction items (opcode plus two operand bytes) and mirrors A, X,
// SP, flags, PC and the data RAM in a local instruction model. Every returned
// state item is checked field by field against the model, in order. Covers
// directed corner cases, a pause until the block drains, and a long random
// mix with random gaps and output stalls.
// ----------------------------------------------------------------------------
module testbench;

	localparam int unsigned MEM_BITS    = 16;
	localparam int unsigned QUIET_LIMIT = 1000;
	localparam int unsigned RANDOM_ITEMS = 1850;

	// Opcodes outside the supported set
	localparam logic [7:0] OPC_UNKNOWN_LO = 8'h00;
	localparam logic [7:0] OPC_UNKNOWN_HI = 8'hFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	c65_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	c65_pkg::rsp_t rsp;

	// Instruction model state
	logic [7:0]  cpu_a = '0;
	logic [7:0]  cpu_x = '0;
	logic [7:0]  cpu_sp = '0;
	logic [7:0]  cpu_flags = '0;
	logic [15:0] cpu_pc = '0;
	logic [7:0]  ram_image [logic [15:0]];
	logic [15:0] stored_addrs [$];

	c65_pkg::rsp_t expected_states [$];
	int   mismatches = 0;
	int   quiet_cycles = 0;
	bit   tx_idle_en = 1'b1;
	bit   rx_idle_en = 1'b1;

	cpu6502_subset_executor #(
		.MEM_ADDR_BITS(MEM_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Replace Z and N from a value, keep every other flag
	function automatic logic [7:0] with_zn(input logic [7:0] flags, input logic [7:0] v);
		logic [7:0] f;
		f = flags & ~(c65_pkg::FLAG_Z | c65_pkg::FLAG_N);
		if (v == 8'd0) begin
			f = f | c65_pkg::FLAG_Z;
		end
		if (v[7]) begin
			f = f | c65_pkg::FLAG_N;
		end
		return f;
	endfunction

	// Execute one instruction on the model and queue the state it yields
	task automatic execute_model(input c65_pkg::req_t item);
		c65_pkg::rsp_t r;
		logic [15:0]   addr;
		logic [15:0]   pc_next;
		addr = {item.operand_high, item.operand_low} & 16'((32'd1 << MEM_BITS) - 1);
		pc_next = cpu_pc;
		r.status = c65_pkg::STATUS_OK;
		case (item.opcode)
			c65_pkg::OPC_CLD: begin
				cpu_flags = cpu_flags & c65_pkg::CLR_D_MASK;
				pc_next = pc_next + 16'd1;
			end
			c65_pkg::OPC_SEI: begin
				cpu_flags = cpu_flags | c65_pkg::FLAG_I;
				pc_next = pc_next + 16'd1;
			end
			c65_pkg::OPC_LDX: begin
				cpu_x = item.operand_low;
				cpu_flags = with_zn(cpu_flags, cpu_x);
				pc_next = pc_next + 16'd2;
			end
			c65_pkg::OPC_STX: begin
				if (!ram_image.exists(addr)) begin
					stored_addrs.push_back(addr);
				end
				ram_image[addr] = cpu_x;
				pc_next = pc_next + 16'd3;
			end
			c65_pkg::OPC_LDA: begin
				cpu_a = ram_image.exists(addr) ? ram_image[addr] : 8'd0;
				cpu_flags = with_zn(cpu_flags, cpu_a);
				pc_next = pc_next + 16'd3;
			end
			c65_pkg::OPC_BPL: begin
				// Branch when N is clear, offset is signed
				if ((cpu_flags & c65_pkg::FLAG_N) == 8'd0) begin
					pc_next = pc_next + 16'd2
						+ {{8{item.operand_low[7]}}, item.operand_low};
				end else begin
					pc_next = pc_next + 16'd2;
				end
			end
			c65_pkg::OPC_DEX: begin
				cpu_x = cpu_x - 8'd1;
				cpu_flags = with_zn(cpu_flags, cpu_x);
				pc_next = pc_next + 16'd1;
			end
			c65_pkg::OPC_TXS: begin
				cpu_sp = cpu_x;
				pc_next = pc_next + 16'd1;
			end
			default: begin
				r.status = c65_pkg::STATUS_BAD;
			end
		endcase
		cpu_pc = pc_next;
		r.next_pc = cpu_pc;
		r.acc_out = cpu_a;
		r.xreg_out = cpu_x;
		r.stack_out = cpu_sp;
		r.flags_out = cpu_flags;
		expected_states.push_back(r);
	endtask

	// Offer one item, hold it until accepted, then update the model
	task automatic send_instr(input c65_pkg::req_t item);
		while (tx_idle_en && $urandom_range(99) < 25) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do begin
			@(posedge clk);
		end while (req_stall !== 1'b0);
		execute_model(item);
	endtask

	// Draw a random instruction; loads only read bytes already stored
	function automatic c65_pkg::req_t random_instr();
		c65_pkg::req_t item;
		int unsigned   pick;
		logic [15:0]   a;
		item.operand_low = 8'($urandom);
		item.operand_high = 8'($urandom);
		pick = $urandom_range(99);
		if (pick < 10) begin
			do begin
				item.opcode = 8'($urandom);
			end while (item.opcode inside {c65_pkg::OPC_CLD, c65_pkg::OPC_SEI,
				c65_pkg::OPC_LDX, c65_pkg::OPC_STX, c65_pkg::OPC_LDA,
				c65_pkg::OPC_BPL, c65_pkg::OPC_DEX, c65_pkg::OPC_TXS});
		end else if (pick < 16) begin
			item.opcode = c65_pkg::OPC_CLD;
		end else if (pick < 22) begin
			item.opcode = c65_pkg::OPC_SEI;
		end else if (pick < 40) begin
			item.opcode = c65_pkg::OPC_LDX;
		end else if (pick < 55) begin
			item.opcode = c65_pkg::OPC_STX;
			// Reuse a stored address half the time to overwrite bytes
			if (stored_addrs.size() != 0 && $urandom_range(1)) begin
				a = stored_addrs[$urandom_range(stored_addrs.size() - 1)];
				{item.operand_high, item.operand_low} = a;
			end
		end else if (pick < 70) begin
			if (stored_addrs.size() != 0) begin
				item.opcode = c65_pkg::OPC_LDA;
				a = stored_addrs[$urandom_range(stored_addrs.size() - 1)];
				{item.operand_high, item.operand_low} = a;
			end else begin
				item.opcode = c65_pkg::OPC_STX;
			end
		end else if (pick < 85) begin
			item.opcode = c65_pkg::OPC_BPL;
		end else if (pick < 94) begin
			item.opcode = c65_pkg::OPC_DEX;
		end else begin
			item.opcode = c65_pkg::OPC_TXS;
		end
		return item;
	endfunction

	task automatic compare_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Check each accepted result against the oldest expectation
	always @(posedge clk) begin
		c65_pkg::rsp_t want;
		if (arst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			if (expected_states.size() == 0) begin
				$display("%0t: result with nothing expected, actual %h", $time, rsp);
				mismatches++;
			end else begin
				want = expected_states.pop_front();
				compare_field("status", 16'(want.status), 16'(rsp.status));
				compare_field("next_pc", want.next_pc, rsp.next_pc);
				compare_field("acc_out", 16'(want.acc_out), 16'(rsp.acc_out));
				compare_field("xreg_out", 16'(want.xreg_out), 16'(rsp.xreg_out));
				compare_field("stack_out", 16'(want.stack_out), 16'(rsp.stack_out));
				compare_field("flags_out", 16'(want.flags_out), 16'(rsp.flags_out));
			end
		end
	end

	// Stall the result side at random
	always @(posedge clk) begin
		rsp_stall <= rx_idle_en && ($urandom_range(99) < 25);
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (req_valid === 1'b1 && req_stall === 1'b0)
			|| (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Corner cases: every opcode, flag extremes, branch limits, PC wrap
	task automatic test_directed();
		send_instr({OPC_UNKNOWN_LO, 8'h00, 8'h00});
		send_instr({c65_pkg::OPC_SEI, 8'hFF, 8'hFF});
		send_instr({c65_pkg::OPC_CLD, 8'h00, 8'h00});
		// N is clear after reset: backward branch wraps PC below zero
		send_instr({c65_pkg::OPC_BPL, 8'h80, 8'h00});
		send_instr({c65_pkg::OPC_LDX, 8'h00, 8'hFF});
		send_instr({c65_pkg::OPC_TXS, 8'h00, 8'h00});
		send_instr({c65_pkg::OPC_STX, 8'h00, 8'h00});
		send_instr({c65_pkg::OPC_LDX, 8'hFF, 8'h00});
		send_instr({c65_pkg::OPC_STX, 8'hFF, 8'hFF});
		send_instr({c65_pkg::OPC_STX, 8'hA5, 8'h5A});
		send_instr({c65_pkg::OPC_LDA, 8'h00, 8'h00});
		send_instr({c65_pkg::OPC_LDA, 8'hFF, 8'hFF});
		// N set: branch falls through
		send_instr({c65_pkg::OPC_BPL, 8'h10, 8'h00});
		send_instr({c65_pkg::OPC_LDX, 8'h01, 8'h00});
		send_instr({c65_pkg::OPC_DEX, 8'h00, 8'h00});
		send_instr({c65_pkg::OPC_DEX, 8'h00, 8'h00});
		send_instr({c65_pkg::OPC_TXS, 8'h00, 8'h00});
		send_instr({c65_pkg::OPC_LDX, 8'h7F, 8'h00});
		send_instr({c65_pkg::OPC_BPL, 8'h7F, 8'h00});
		send_instr({c65_pkg::OPC_BPL, 8'h80, 8'hFF});
		send_instr({c65_pkg::OPC_BPL, 8'hFE, 8'h00});
		send_instr({c65_pkg::OPC_LDA, 8'hA5, 8'h5A});
		send_instr({OPC_UNKNOWN_HI, 8'hFF, 8'hFF});
		send_instr({c65_pkg::OPC_CLD, 8'hFF, 8'hFF});
	endtask

	// Hold the sender until the block has returned every result
	task automatic test_drain_pause();
		repeat (8) begin
			send_instr(random_instr());
		end
		req_valid <= 1'b0;
		while (expected_states.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) begin
			send_instr(random_instr());
		end
	endtask

	// Long random mix with a stretch where neither side idles
	task automatic test_random_mix();
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			tx_idle_en = !(i >= 600 && i < 900);
			rx_idle_en = tx_idle_en;
			send_instr(random_instr());
		end
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_drain_pause();
		test_random_mix();
		req_valid <= 1'b0;
		while (expected_states.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
